FILE: hdl/ftjc_pkg.sv
// ftjc_pkg: shared constants for the frame time jank classifier
// no dependencies
package ftjc_pkg;
    localparam int WINDOW_MAX = 1024;
    localparam int TIME_BITS  = 24;
    localparam int CNT_BITS = 32;
    localparam logic [2:0] SEV_NONE     = 3'd0;
    localparam logic [2:0] SEV_MICRO    = 3'd1;
    localparam logic [2:0] SEV_MODERATE = 3'd2;
    localparam logic [2:0] SEV_SEVERE   = 3'd3;
    localparam logic [2:0] SEV_CRITICAL = 3'd4;
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;
    localparam logic CFG_WINDOW_LEN = 1'b0;
    localparam logic CFG_ABS_LIMIT  = 1'b1;
    localparam logic [9:0] SCORE_FULL = 10'd1000;
endpackage

FILE: hdl/ftjc_divider.sv
// ftjc_divider: restoring serial divider, one quotient bit per cycle
// depends on nothing
module ftjc_divider #(
    parameter int NUM_BITS = 34,
    parameter int DEN_BITS = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [NUM_BITS-1:0] quo
);
    localparam int CB = $clog2(NUM_BITS + 1);
    logic [NUM_BITS-1:0] quo_reg;
    logic [DEN_BITS:0]   rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [CB-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DEN_BITS+1:0] trial;

    assign trial = {rem_reg, quo_reg[NUM_BITS-1]} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CB'(NUM_BITS);
                quo_reg  <= num;
                rem_reg  <= '0;
                den_reg  <= den;
            end
            else if (busy_reg)
            begin
                if (!trial[DEN_BITS+1])
                begin
                    rem_reg <= trial[DEN_BITS:0];
                    quo_reg <= {quo_reg[NUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[DEN_BITS-1:0], quo_reg[NUM_BITS-1]};
                    quo_reg <= {quo_reg[NUM_BITS-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CB'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

FILE: hdl/frame_time_jank_classifier_top.sv
// frame_time_jank_classifier_top: windowed frame time jank classifier
// depends on ftjc_pkg and ftjc_divider
// Each transfer takes a frame time or a clear. A record drops old window entries through the
// ring read port, one at a time and every extra one when the window length is lowered, then
// does up to five severity compares one per cycle on a shared multiply and compare unit, then
// a serial division for the average; with a zero window length there is no division. A clear
// goes straight to the output state. The result is held in output registers until taken; the
// next item is accepted while it waits, and its own result then waits in the sequencer until
// the first is taken.
module frame_time_jank_classifier_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [23:0] frame_time_us,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  severity,
    output logic        alert,
    output logic [31:0] frame_count,
    output logic [23:0] avg_frame_us,
    output logic [10:0] window_fill,
    output logic [31:0] micro_total,
    output logic [31:0] moderate_total,
    output logic [31:0] severe_total,
    output logic [31:0] critical_total,
    output logic [9:0]  smoothness_tenths
);
    import ftjc_pkg::*;
    localparam int AB = $clog2(WINDOW_MAX);
    localparam int FB = AB + 1;
    localparam int SB = TIME_BITS + FB;
    localparam int PB = SB + 3;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_DROP, S_PUSH, S_CMP, S_CNT, S_PEN, S_DIV, S_OUT
    } state_t;

    state_t state_reg;
    logic [10:0] wlen_reg;
    logic [23:0] limit_reg;
    logic [TIME_BITS-1:0] ring [WINDOW_MAX];
    logic [TIME_BITS-1:0] rd_reg, f_reg;
    logic [AB-1:0] head_reg;
    logic [FB-1:0] fill_reg, lim_reg;
    logic [SB-1:0] sum_reg;
    logic [31:0] frames_reg;
    logic [31:0] cnt_reg [4];
    logic [2:0] step_reg, sev_reg;
    logic [PB-1:0] lhs_reg, rhs;
    logic [41:0] pen_reg;
    logic div_start_reg, div_done;
    logic [SB-1:0] quo;
    logic out_valid_reg;

    // shared multiply and compare: step 0 critical, 1 severe, 2 limit, 3 moderate, 4 micro
    always_comb begin
        case (step_reg)
            3'd0:    rhs = PB'(sum_reg) * PB'(5);
            3'd1:    rhs = PB'(sum_reg) * PB'(3);
            3'd3:    rhs = PB'(sum_reg) << 1;
            3'd4:    rhs = PB'(sum_reg) * PB'(3);
            default: rhs = '0;
        endcase
    end

    ftjc_divider #(.NUM_BITS(SB), .DEN_BITS(FB)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start_reg), .num(sum_reg),
        .den(fill_reg), .done(div_done), .quo(quo)
    );

    always_ff @(posedge clk) begin
        if (state_reg == S_PUSH && lim_reg != '0)
            ring[AB'(head_reg + fill_reg[AB-1:0])] <= f_reg;
        rd_reg <= ring[head_reg];
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wlen_reg <= 11'd600; limit_reg <= 24'd100000;
            head_reg <= '0; fill_reg <= '0; sum_reg <= '0; frames_reg <= '0;
            for (int i = 0; i < 4; i++) cnt_reg[i] <= '0;
            out_valid_reg <= 1'b0; div_start_reg <= 1'b0;
            sev_reg <= SEV_NONE; step_reg <= '0;
            f_reg <= '0; lim_reg <= '0; lhs_reg <= '0; pen_reg <= '0;
            severity <= SEV_NONE; alert <= 1'b0; frame_count <= '0;
            avg_frame_us <= '0; window_fill <= '0;
            micro_total <= '0; moderate_total <= '0;
            severe_total <= '0; critical_total <= '0;
            smoothness_tenths <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (state_reg == S_OUT && (!out_valid_reg || out_ready)) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_WINDOW_LEN) wlen_reg <= cfg_data[10:0];
                else limit_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                    if (in_valid && in_ready)
                    begin
                        if (op == OP_CLEAR)
                        begin
                            head_reg <= '0; fill_reg <= '0; sum_reg <= '0;
                            frames_reg <= '0; sev_reg <= SEV_NONE;
                            for (int i = 0; i < 4; i++) cnt_reg[i] <= '0;
                            pen_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            f_reg <= frame_time_us[TIME_BITS-1:0];
                            lim_reg <= (32'(wlen_reg) > WINDOW_MAX) ? FB'(WINDOW_MAX)
                                                                   : FB'(wlen_reg);
                            state_reg <= S_READ;
                        end
                    end
                S_READ:
                    state_reg <= (fill_reg != '0 && fill_reg >= lim_reg) ? S_DROP : S_PUSH;
                S_DROP:
                begin
                    sum_reg <= sum_reg - SB'(rd_reg);
                    head_reg <= AB'(head_reg + 1'b1);
                    fill_reg <= fill_reg - 1'b1;
                    state_reg <= S_READ;
                end
                S_PUSH:
                begin
                    if (lim_reg != '0)
                    begin
                        sum_reg <= sum_reg + SB'(f_reg);
                        fill_reg <= fill_reg + 1'b1;
                        lhs_reg <= PB'(f_reg) * PB'(fill_reg + 1'b1);
                    end
                    else lhs_reg <= '0;
                    if (frames_reg != '1) frames_reg <= frames_reg + 1'b1;
                    step_reg <= '0;
                    sev_reg <= SEV_NONE;
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (sum_reg == '0) state_reg <= S_CNT;
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                        state_reg <= (step_reg == 3'd4) ? S_CNT : S_CMP;
                        case (step_reg)
                            3'd0: if (lhs_reg > rhs)
                                  begin sev_reg <= SEV_CRITICAL; state_reg <= S_CNT; end
                            3'd1: if (lhs_reg > rhs)
                                  begin sev_reg <= SEV_SEVERE; state_reg <= S_CNT; end
                            3'd2:
                            begin
                                if (32'(f_reg) > 32'(limit_reg))
                                begin sev_reg <= SEV_MODERATE; state_reg <= S_CNT; end
                                lhs_reg <= lhs_reg;
                            end
                            3'd3:
                            begin
                                if (lhs_reg > rhs)
                                begin sev_reg <= SEV_MODERATE; state_reg <= S_CNT; end
                                lhs_reg <= lhs_reg << 1;
                            end
                            3'd4: if (lhs_reg > rhs) sev_reg <= SEV_MICRO;
                            default: state_reg <= S_CNT;
                        endcase
                    end
                end
                S_CNT:
                begin
                    if (sev_reg != SEV_NONE && cnt_reg[2'(sev_reg - 1'b1)] != '1)
                        cnt_reg[2'(sev_reg - 1'b1)] <= cnt_reg[2'(sev_reg - 1'b1)] + 1'b1;
                    state_reg <= S_PEN;
                end
                S_PEN:
                begin
                    pen_reg <= 42'(cnt_reg[0]) + 42'(cnt_reg[1]) * 42'd5
                             + 42'(cnt_reg[2]) * 42'd20 + 42'(cnt_reg[3]) * 42'd50;
                    if (fill_reg != '0)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg <= S_DIV;
                    end
                    else state_reg <= S_OUT;
                end
                S_DIV:
                    if (div_done) state_reg <= S_OUT;
                S_OUT:
                    if (!out_valid_reg || out_ready)
                    begin
                        severity <= sev_reg;
                        alert <= (sev_reg >= SEV_MODERATE);
                        frame_count <= frames_reg;
                        avg_frame_us <= (fill_reg != '0) ? 24'(quo) : 24'd0;
                        window_fill <= 11'(fill_reg);
                        micro_total <= cnt_reg[0];
                        moderate_total <= cnt_reg[1];
                        severe_total <= cnt_reg[2];
                        critical_total <= cnt_reg[3];
                        smoothness_tenths <= (pen_reg >= 42'(SCORE_FULL)) ? 10'd0
                                             : SCORE_FULL - 10'(pen_reg);
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
    assign out_valid = out_valid_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= WINDOW_MAX) else $error("fill over window size");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    a_alert: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (alert == (severity >= SEV_MODERATE))) else $error("alert mismatch");
endmodule

FILE: dv/frame_time_jank_classifier_top_tb.sv
// frame_time_jank_classifier_top_tb: randomized and directed check of the jank classifier
// predicts every result with its own model of window, average, severity and counters
// depends on ftjc_pkg and the frame_time_jank_classifier_top rtl
module frame_time_jank_classifier_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ftjc_pkg::*;

    typedef struct packed {
        logic [2:0]  severity;
        logic        alert;
        logic [31:0] frame_count;
        logic [23:0] avg_frame_us;
        logic [10:0] window_fill;
        logic [31:0] micro_total;
        logic [31:0] moderate_total;
        logic [31:0] severe_total;
        logic [31:0] critical_total;
        logic [9:0]  smoothness_tenths;
    } jank_report_t;

    class jank_scoreboard;
        logic [23:0] frame_ring [1024];
        int unsigned head;
        int unsigned fill;
        longint unsigned sum;
        longint unsigned frames;
        longint unsigned counts [4];
        int unsigned win_len;
        longint unsigned abs_limit;
        jank_report_t pending [$];
        int errors;

        function new();
            win_len = 600;
            abs_limit = 100000;
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            head = 0;
            fill = 0;
            sum = 0;
            frames = 0;
            for (int i = 0; i < 4; i++) counts[i] = 0;
        endfunction

        function void set_reg(logic idx, logic [23:0] data);
            if (idx == CFG_WINDOW_LEN) win_len = data[10:0];
            else abs_limit = data;
        endfunction

        function logic [2:0] grade(longint unsigned f);
            longint unsigned fn;
            if (sum == 0 || fill == 0) return SEV_NONE;
            fn = f * fill;
            if (fn > 5 * sum) return SEV_CRITICAL;
            if (fn > 3 * sum) return SEV_SEVERE;
            if (f > abs_limit) return SEV_MODERATE;
            if (fn > 2 * sum) return SEV_MODERATE;
            if (2 * fn > 3 * sum) return SEV_MICRO;
            return SEV_NONE;
        endfunction

        function void note_input(logic opc, logic [23:0] ft);
            jank_report_t r;
            logic [2:0] sev;
            int unsigned lim;
            longint unsigned pen;
            sev = SEV_NONE;
            if (opc == OP_CLEAR) wipe();
            else begin
                lim = (win_len > 1024) ? 1024 : win_len;
                while (fill > 0 && fill + 1 > lim) begin
                    sum -= frame_ring[head];
                    head = (head + 1) % 1024;
                    fill--;
                end
                if (lim > 0) begin
                    frame_ring[(head + fill) % 1024] = ft;
                    sum += ft;
                    fill++;
                end
                if (frames != 64'hFFFFFFFF) frames++;
                sev = grade(ft);
                if (sev != SEV_NONE && counts[sev - 1] != 64'hFFFFFFFF) counts[sev - 1]++;
            end
            pen = counts[0] + 5 * counts[1] + 20 * counts[2] + 50 * counts[3];
            r.severity = sev;
            r.alert = (sev >= SEV_MODERATE);
            r.frame_count = frames[31:0];
            r.avg_frame_us = fill ? 24'(sum / fill) : 24'd0;
            r.window_fill = fill[10:0];
            r.micro_total = counts[0][31:0];
            r.moderate_total = counts[1][31:0];
            r.severe_total = counts[2][31:0];
            r.critical_total = counts[3][31:0];
            r.smoothness_tenths = (pen >= 1000) ? 10'd0 : 10'(1000 - pen);
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(jank_report_t a);
            jank_report_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (a.severity !== e.severity) begin
                $error("severity exp %0d got %0d", e.severity, a.severity); errors++;
            end
            if (a.alert !== e.alert) begin
                $error("alert exp %0d got %0d", e.alert, a.alert); errors++;
            end
            if (a.frame_count !== e.frame_count) begin
                $error("frame_count exp %0d got %0d", e.frame_count, a.frame_count);
                errors++;
            end
            if (a.avg_frame_us !== e.avg_frame_us) begin
                $error("avg_frame_us exp %0d got %0d", e.avg_frame_us, a.avg_frame_us);
                errors++;
            end
            if (a.window_fill !== e.window_fill) begin
                $error("window_fill exp %0d got %0d", e.window_fill, a.window_fill); errors++;
            end
            if (a.micro_total !== e.micro_total) begin
                $error("micro_total exp %0d got %0d", e.micro_total, a.micro_total); errors++;
            end
            if (a.moderate_total !== e.moderate_total) begin
                $error("moderate_total exp %0d got %0d", e.moderate_total, a.moderate_total);
                errors++;
            end
            if (a.severe_total !== e.severe_total) begin
                $error("severe_total exp %0d got %0d", e.severe_total, a.severe_total);
                errors++;
            end
            if (a.critical_total !== e.critical_total) begin
                $error("critical_total exp %0d got %0d", e.critical_total, a.critical_total);
                errors++;
            end
            if (a.smoothness_tenths !== e.smoothness_tenths) begin
                $error("smoothness_tenths exp %0d got %0d", e.smoothness_tenths,
                       a.smoothness_tenths);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [23:0] frame_time_us;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [23:0] cfg_data;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  severity;
    logic        alert;
    logic [31:0] frame_count;
    logic [23:0] avg_frame_us;
    logic [10:0] window_fill;
    logic [31:0] micro_total;
    logic [31:0] moderate_total;
    logic [31:0] severe_total;
    logic [31:0] critical_total;
    logic [9:0]  smoothness_tenths;
    jank_report_t got;

    jank_scoreboard sb;
    bit          hold_off;
    bit          feeding_done;
    longint      cycle_count;

    frame_time_jank_classifier_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .frame_time_us(frame_time_us),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .severity(severity), .alert(alert), .frame_count(frame_count),
        .avg_frame_us(avg_frame_us), .window_fill(window_fill),
        .micro_total(micro_total), .moderate_total(moderate_total),
        .severe_total(severe_total), .critical_total(critical_total),
        .smoothness_tenths(smoothness_tenths)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    int burst_left = 0;

    task automatic send_frame(logic opc, logic [23:0] ft);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 60);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        op <= opc;
        frame_time_us <= ft;
        do @(posedge clk); while (!in_ready);
        sb.note_input(opc, ft);
    endtask

    task automatic write_reg(logic idx, logic [23:0] data);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [23:0] pick_time();
        case ($urandom_range(0, 9))
            0: return 24'($urandom);
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(0, 3));
            3, 4: return 24'($urandom_range(16000, 17000) *
                             (($urandom_range(0, 3) == 0) ? 6 : 1));
            5: return 24'($urandom_range(0, 400000));
            default: return 24'($urandom_range(15000, 60000));
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got = {severity, alert, frame_count, avg_frame_us, window_fill, micro_total,
                   moderate_total, severe_total, critical_total, smoothness_tenths};
            sb.check_result(got);
        end
    end

    int stall_mode;
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_off) out_ready <= 1'b0;
            else begin
                stall_mode = (cycle_count / 3000) % 3;
                if (stall_mode == 0) out_ready <= 1'b1;
                else if (stall_mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
                else out_ready <= ((cycle_count % 7) < 2);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 3000000) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        hold_off = 1'b0;
        @(posedge rst_n);
        repeat (5000) @(posedge clk);
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        sb = new();
        feeding_done = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_RECORD;
        frame_time_us = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WINDOW_LEN;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(OP_RECORD, 24'd0);
        send_frame(OP_RECORD, 24'd16000);
        send_frame(OP_RECORD, 24'd16000);
        send_frame(OP_RECORD, 24'd30000);
        send_frame(OP_RECORD, 24'd60000);
        send_frame(OP_RECORD, 24'd200000);
        send_frame(OP_RECORD, 24'hFFFFFF);
        send_frame(OP_RECORD, 24'd1);
        send_frame(OP_CLEAR, 24'hFFFFFF);
        send_frame(OP_RECORD, 24'd100001);
        write_reg(CFG_WINDOW_LEN, 24'd0);
        send_frame(OP_RECORD, 24'd5000);
        send_frame(OP_RECORD, 24'd9000);
        write_reg(CFG_WINDOW_LEN, 24'd1);
        send_frame(OP_RECORD, 24'd5000);
        send_frame(OP_RECORD, 24'd50000);
        write_reg(CFG_ABS_LIMIT, 24'd0);
        write_reg(CFG_WINDOW_LEN, 24'd4);
        send_frame(OP_RECORD, 24'd10);
        send_frame(OP_RECORD, 24'd10);
        send_frame(OP_RECORD, 24'd11);
        send_frame(OP_RECORD, 24'd40);
        write_reg(CFG_WINDOW_LEN, 24'h7FF);
        write_reg(CFG_ABS_LIMIT, 24'hFFFFFF);
        send_frame(OP_RECORD, 24'd20);
        send_frame(OP_RECORD, 24'd100);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_reg(CFG_WINDOW_LEN, 24'd600);
                1: write_reg(CFG_WINDOW_LEN, 24'd3);
                2: write_reg(CFG_WINDOW_LEN, 24'd1024);
                3: write_reg(CFG_WINDOW_LEN, 24'd17);
                4: write_reg(CFG_WINDOW_LEN, 24'h7FF);
                5: write_reg(CFG_WINDOW_LEN, 24'd1);
                6: write_reg(CFG_WINDOW_LEN, 24'd0);
                default: write_reg(CFG_WINDOW_LEN, {13'd0, 11'($urandom)});
            endcase
            write_reg(CFG_ABS_LIMIT, (phase % 3 == 0) ? 24'd100000 :
                      (phase % 3 == 1) ? 24'($urandom) : 24'd20000);
            for (int i = 0; i < 135; i++) begin
                if ($urandom_range(0, 150) == 0) send_frame(OP_CLEAR, 24'($urandom));
                else send_frame(OP_RECORD, pick_time());
            end
        end
        feeding_done = 1;
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
